### design/pps_pkg.sv
// Shared word types, field widths and codes for the priority scheduler.
`default_nettype none
package pps_pkg;

   localparam int POOL_DEPTH_DEFAULT    = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;

   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int LEVEL_W = 8;
   localparam int WAIT_W  = 32;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [ID_W-1:0]    proc_id;
      logic [BURST_W-1:0] burst_length;
      logic [LEVEL_W-1:0] priority_level;
   } req_word_type;

   typedef struct packed {
      logic              arrival_accepted;
      logic              dispatched;
      logic              preempted;
      logic              running_valid;
      logic [ID_W-1:0]   running_id;
      logic              idle;
      logic [WAIT_W-1:0] wait_total;
   } rsp_word_type;

endpackage
`default_nettype wire

### design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: job pool in a synchronous RAM, scanned per tick.
//
//  Channel | Ports                          | Direction | Word
//  --------+--------------------------------+-----------+------------------------------
//  req     | req_valid, req_ready, req_data | in        | arrival or tick command
//  rsp     | rsp_valid, rsp_ready, rsp_data | out       | flags, running job, wait sum
//
// One word is processed at a time. A tick goes through the accept step, a scan that
// reads every slot through the registered RAM read port, an update step and a step to
// post the result. An arrival searches upward from slot 0 for the first free slot and
// writes the job there; with a full pool the arrival goes straight to the result.
// Reset clears the valid bits, the pool count and the running job; the RAM is not cleared.
// A result held by rsp_ready does not block the next req word; only the next result waits.
`default_nettype none
module preemptive_priority_scheduler #(
   parameter int POOL_DEPTH    = pps_pkg::POOL_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  pps_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output pps_pkg::rsp_word_type rsp_data
);
   import pps_pkg::*;

   localparam int IDX_W   = $clog2(POOL_DEPTH);
   localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
   localparam int ENTRY_W = ID_W + BURST_W + PRIORITY_BITS;
   localparam int WSUM_W  = WAIT_W + 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FIND   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // pool RAM: {id, remaining, priority}; valid bits live in flops
   logic [ENTRY_W-1:0]       pool_mem_ff [POOL_DEPTH];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;

   logic [POOL_DEPTH-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   req_word_type             req_ff, req_in;

   logic                     run_active_ff, run_active_in;
   logic [ID_W-1:0]          run_id_ff, run_id_in;
   logic [BURST_W-1:0]       run_rem_ff, run_rem_in;
   logic [PRIORITY_BITS-1:0] run_prio_ff, run_prio_in;
   logic [WAIT_W-1:0]        wait_ff, wait_in;

   logic                     best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [ID_W-1:0]          best_id_ff, best_id_in;
   logic [BURST_W-1:0]       best_rem_ff, best_rem_in;
   logic [PRIORITY_BITS-1:0] best_prio_ff, best_prio_in;

   logic                     acc_ff, acc_in;
   logic                     disp_ff, disp_in;
   logic                     pre_ff, pre_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_data_ff, rsp_data_in;

   // helpers
   logic [IDX_W-1:0]               scan_idx;
   logic [CNT_W-1:0]               cnt_prev;
   logic [ID_W-1:0]                rd_id;
   logic [BURST_W-1:0]             rd_rem;
   logic [PRIORITY_BITS-1:0]       rd_prio;
   logic [PRIORITY_BITS+LEVEL_W-1:0] prio_ext;
   logic [BURST_W-1:0]             upd_rem;
   logic [WSUM_W-1:0]              wait_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign cnt_prev = cnt_ff - CNT_W'(1);
   assign scan_idx = cnt_prev[IDX_W-1:0];
   assign rd_id    = rd_data_ff[ENTRY_W-1 -: ID_W];
   assign rd_rem   = rd_data_ff[PRIORITY_BITS +: BURST_W];
   assign rd_prio  = rd_data_ff[PRIORITY_BITS-1:0];
   // keep the low PRIORITY_BITS of the level, zero-extended if wider
   assign prio_ext = {{PRIORITY_BITS{1'b0}}, req_ff.priority_level};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      run_active_in = run_active_ff;
      run_id_in     = run_id_ff;
      run_rem_in    = run_rem_ff;
      run_prio_in   = run_prio_ff;
      wait_in       = wait_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_rem_in   = best_rem_ff;
      best_prio_in  = best_prio_ff;
      acc_in        = acc_ff;
      disp_in       = disp_ff;
      pre_in        = pre_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      wr_data       = {req_ff.proc_id, req_ff.burst_length,
                       prio_ext[PRIORITY_BITS-1:0]};
      upd_rem       = run_rem_ff;
      wait_sum      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               acc_in  = 1'b0;
               disp_in = 1'b0;
               pre_in  = 1'b0;
               cnt_in  = '0;
               if (req_data.opcode == OP_TICK) begin
                  // retire a finished job before the scan
                  if (run_active_ff && run_rem_ff == '0) begin
                     run_active_in = 1'b0;
                     run_id_in     = '0;
                     run_prio_in   = '0;
                  end
                  best_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end else if (count_ff == CNT_W'(POOL_DEPTH)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (!used_ff[cnt_ff[IDX_W-1:0]]) begin
               mem_we                       = 1'b1;
               used_in[cnt_ff[IDX_W-1:0]]   = 1'b1;
               count_in                     = count_ff + CNT_W'(1);
               acc_in                       = 1'b1;
               state_in                     = ST_RESP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the slot addressed in the previous cycle
            if (cnt_ff != '0) begin
               if (used_ff[scan_idx] && (!best_valid_ff || rd_prio < best_prio_ff)) begin
                  best_valid_in = 1'b1;
                  best_idx_in   = scan_idx;
                  best_id_in    = rd_id;
                  best_rem_in   = rd_rem;
                  best_prio_in  = rd_prio;
               end
            end
            if (cnt_ff == CNT_W'(POOL_DEPTH)) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            if (best_valid_ff && run_active_ff && best_prio_ff < run_prio_ff) begin
               // swap: displaced job takes the slot the new one leaves
               mem_we      = 1'b1;
               wr_addr     = best_idx_ff;
               wr_data     = {run_id_ff, run_rem_ff, run_prio_ff};
               run_id_in   = best_id_ff;
               run_prio_in = best_prio_ff;
               upd_rem     = best_rem_ff;
               disp_in     = 1'b1;
               pre_in      = 1'b1;
            end else if (best_valid_ff && !run_active_ff) begin
               run_active_in        = 1'b1;
               run_id_in            = best_id_ff;
               run_prio_in          = best_prio_ff;
               upd_rem              = best_rem_ff;
               used_in[best_idx_ff] = 1'b0;
               count_in             = count_ff - CNT_W'(1);
               disp_in              = 1'b1;
            end
            run_rem_in = (run_active_in && upd_rem != '0) ? upd_rem - BURST_W'(1) : upd_rem;
            wait_sum   = {1'b0, wait_ff} + WSUM_W'(count_in);
            wait_in    = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.arrival_accepted = acc_ff;
               rsp_data_in.dispatched       = disp_ff;
               rsp_data_in.preempted        = pre_ff;
               rsp_data_in.running_valid    = run_active_ff;
               rsp_data_in.running_id       = run_active_ff ? run_id_ff : '0;
               rsp_data_in.idle             = !run_active_ff && count_ff == '0;
               rsp_data_in.wait_total       = wait_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pool RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= pool_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         count_ff      <= '0;
         run_active_ff <= 1'b0;
         run_id_ff     <= '0;
         run_rem_ff    <= '0;
         run_prio_ff   <= '0;
         wait_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
         run_active_ff <= run_active_in;
         run_id_ff     <= run_id_in;
         run_rem_ff    <= run_rem_in;
         run_prio_ff   <= run_prio_in;
         wait_ff       <= wait_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      best_rem_ff  <= best_rem_in;
      best_prio_ff <= best_prio_in;
      acc_ff       <= acc_in;
      disp_ff      <= disp_in;
      pre_ff       <= pre_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire
